// ===== hw/rtl/tlpq_pkg.sv =====
// Package for the three-level priority queue: sizes, codes and transaction types.
// No dependencies; every other file in hw/rtl imports it.
`default_nettype none

package tlpq_pkg;

	localparam int DEPTH        = 16;
	localparam int PAYLOAD_BITS = 16;
	localparam int CNT_W        = $clog2(DEPTH + 1);

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	localparam logic [1:0] LVL_LOW    = 2'd0;
	localparam logic [1:0] LVL_NORMAL = 2'd1;
	localparam logic [1:0] LVL_HIGH   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        op;
		logic [15:0] payload;
		logic [1:0]  level;
	} req_t;

	typedef struct packed {
		logic [15:0] out_payload;
		logic [1:0]  out_level;
		logic [1:0]  status;
		logic        now_empty;
		logic [4:0]  stored_count;
	} rsp_t;

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] payload;
		logic [1:0]              level;
	} entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic       put;
		logic       take;
		logic [1:0] best_lvl;
		entry_t     new_ent;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/three_level_priority_queue_unit.sv =====
// Three-level strict-priority queue: control, result register and the cell row.
// Depends on tlpq_pkg and tlpq_cell.
// A transaction accepted in IDLE passes through SCAN and EXEC before its result is registered.
// One transaction at a time: the next request is taken only once the result has left the
//   output register, so a stalled result also holds off new requests.
// Reset (arst_n low, asynchronous): queue empty, all cells invalid, no result pending.
// Cell contents are not reset; only cells marked used are ever read.
`default_nettype none

module three_level_priority_queue_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  tlpq_pkg::req_t     req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output tlpq_pkg::rsp_t     rsp
);
	import tlpq_pkg::*;

	// Sequencer: IDLE takes a request, SCAN finds the highest level present,
	// EXEC updates the cell row and builds the result, OUT holds it until taken.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EXEC = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t          state_q;
	req_t            req_q;
	logic [1:0]      best_lvl_q;
	logic [CNT_W-1:0] count_q;
	rsp_t            rsp_q;

	cell_ctl_t       ctl;
	logic [1:0]      put_lvl;
	logic            full;
	logic            empty;
	logic            do_put;
	logic            do_take;
	logic [2:0]      present;
	logic [1:0]      best_lvl;
	entry_t          taken_ent;
	logic [CNT_W-1:0] count_nxt;

	// per-cell chain signals
	logic [DEPTH-1:0] used;
	logic [DEPTH:0]   pick;
	logic [2:0]       lvl_present [DEPTH];
	entry_t           ent_hit     [DEPTH];
	entry_t           ent_fwd     [DEPTH];

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp       = rsp_q;

	// level code 3 is treated as high
	assign put_lvl = (req_q.level > LVL_HIGH) ? LVL_HIGH : req_q.level;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_put  = (state_q == S_EXEC) && (req_q.op == OP_PUT) && !full;
	assign do_take = (state_q == S_EXEC) && (req_q.op == OP_TAKE) && !empty;

	assign ctl.put             = do_put;
	assign ctl.take            = do_take;
	assign ctl.best_lvl        = best_lvl_q;
	assign ctl.new_ent.payload = req_q.payload[PAYLOAD_BITS-1:0];
	assign ctl.new_ent.level   = put_lvl;

	// OR of the level flags of all used cells, and the selected hit entry
	always_comb begin
		present   = '0;
		taken_ent = '0;
		for (int i = 0; i < DEPTH; i++) begin
			present   = present | lvl_present[i];
			taken_ent = taken_ent | ent_hit[i];
		end
	end

	always_comb begin
		priority if (present[2]) begin
			best_lvl = LVL_HIGH;
		end else if (present[1]) begin
			best_lvl = LVL_NORMAL;
		end else begin
			best_lvl = LVL_LOW;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_put) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_take) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Cell row, cell 0 oldest. pick ripples from old to young; the first
	// cell at the best level is the one removed.
	assign pick[0] = 1'b0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic   prev_used_w;
		logic   nxt_used_w;
		entry_t nxt_ent_w;

		if (g == 0) begin : g_first
			assign prev_used_w = 1'b1;
		end else begin : g_mid
			assign prev_used_w = used[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign nxt_used_w = 1'b0;
			assign nxt_ent_w  = '0;
		end else begin : g_fwd
			assign nxt_used_w = used[g+1];
			assign nxt_ent_w  = ent_fwd[g+1];
		end

		// every cell exposes its contents to its older neighbor for the shift
		tlpq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.prev_used   (prev_used_w),
			.nxt_ent     (nxt_ent_w),
			.nxt_used    (nxt_used_w),
			.pick_in     (pick[g]),
			.pick_out    (pick[g+1]),
			.used        (used[g]),
			.lvl_present (lvl_present[g]),
			.hit_ent     (ent_hit[g]),
			.ent         (ent_fwd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_OUT;
					count_q <= count_nxt;
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_SCAN) begin
			best_lvl_q <= best_lvl;
		end
		if (state_q == S_EXEC) begin
			rsp_q.out_payload  <= do_take ? 16'(taken_ent.payload) : 16'd0;
			rsp_q.out_level    <= do_take ? taken_ent.level : LVL_LOW;
			if (req_q.op == OP_PUT) begin
				rsp_q.status <= full ? ST_FULL : ST_DONE;
			end else begin
				rsp_q.status <= empty ? ST_EMPTY : ST_DONE;
			end
			rsp_q.now_empty    <= (count_nxt == '0);
			rsp_q.stored_count <= 5'(count_nxt);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlpq_cell.sv =====
// One age-ordered storage cell of the priority queue shift array.
// Depends on tlpq_pkg.
`default_nettype none

module tlpq_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  tlpq_pkg::cell_ctl_t   ctl,
	input  wire                   prev_used,
	input  tlpq_pkg::entry_t      nxt_ent,
	input  wire                   nxt_used,
	input  wire                   pick_in,
	output logic                  pick_out,
	output logic                  used,
	output logic [2:0]            lvl_present,
	output tlpq_pkg::entry_t      hit_ent,
	output tlpq_pkg::entry_t      ent
);
	import tlpq_pkg::*;

	entry_t ent_q;
	logic   used_q;
	logic   match;
	logic   load_new;
	logic   shift_in;

	assign match    = used_q && (ent_q.level == ctl.best_lvl);
	assign pick_out = pick_in | match;
	// first empty cell behind the used ones takes the new entry
	assign load_new = ctl.put && !used_q && prev_used;
	// the picked cell and all younger ones move down by one
	assign shift_in = ctl.take && pick_out;

	assign used    = used_q;
	assign hit_ent = (match && !pick_in) ? ent_q : '0;
	// contents offered to the older neighbor for the shift
	assign ent     = ent_q;

	always_comb begin
		lvl_present = '0;
		if (used_q) begin
			unique case (ent_q.level)
				LVL_LOW:    lvl_present[0] = 1'b1;
				LVL_NORMAL: lvl_present[1] = 1'b1;
				default:    lvl_present[2] = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift_in) begin
			used_q <= nxt_used;
		end else if (load_new) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			ent_q <= nxt_ent;
		end else if (load_new) begin
			ent_q <= ctl.new_ent;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlpq_checker.sv =====
// Port-level checker for the three-level priority queue, bound to the top level.
// Depends on tlpq_pkg and three_level_priority_queue_unit.
`default_nettype none

module tlpq_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                req_stall,
	input wire                rsp_valid,
	input wire                rsp_stall,
	input tlpq_pkg::rsp_t     rsp
);
	import tlpq_pkg::*;

	// a stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.now_empty == (rsp.stored_count == 5'd0)))
		else $error("now_empty disagrees with stored_count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.stored_count <= 5'(DEPTH)))
		else $error("stored_count above depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |->
			(rsp.out_payload == 16'd0) && (rsp.out_level == LVL_LOW))
		else $error("failed transaction returned an entry");

	// a request is never taken while a result is still pending
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request accepted with result pending");

endmodule

bind three_level_priority_queue_unit tlpq_checker u_tlpq_checker (.*);

`default_nettype wire
